// ===== rtl/core/epoch_seconds_to_calendar_date_core_defines.svh =====
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_CORE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define E2C_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define E2C_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/e2c_pkg.sv =====
`default_nettype none

package e2c_pkg;

  // Width of the serial dividend and quotient shift register.
  localparam int unsigned DivW = 32;
  localparam int unsigned DivCntW = $clog2(DivW);

  // Divisors used by the serial divider.
  localparam logic [5:0] SecPerMin  = 6'd60;
  localparam logic [5:0] MinPerHour = 6'd60;
  localparam logic [5:0] HourPerDay = 6'd24;
  localparam logic [5:0] DaysPerWeek = 6'd7;

  // Calendar constants.
  localparam logic [10:0] DaysPerQuad = 11'd1461;
  localparam logic [10:0] DaysPerYear = 11'd365;
  localparam logic [3:0]  MonthFeb    = 4'd1;
  localparam logic [3:0]  MonthDec    = 4'd11;

  // Request into the serial divider.
  typedef struct packed {
    logic       start;
    logic [5:0] divisor;
  } div_req_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      MonthFeb:                                  len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/e2c_sdiv.sv =====
`default_nettype none

// Restoring division by a small divisor, one quotient bit per cycle.
module e2c_sdiv import e2c_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire div_req_t          req_i,
  input  wire logic [DivW-1:0]   dividend_i,
  output logic [DivW-1:0]        quotient_o,
  output logic [5:0]             remainder_o,
  output logic                   busy_o,
  output logic                   done_o
);

  logic [DivW-1:0]    sh_q, sh_d;
  logic [5:0]         rem_q, rem_d;
  logic [5:0]         dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [6:0]         cand;
  logic               ge;

  assign cand = {rem_q, sh_q[DivW-1]};
  assign ge   = (cand >= {1'b0, dvs_q});

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      sh_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d  = {sh_q[DivW-2:0], ge};
      rem_d = ge ? 6'(cand - {1'b0, dvs_q}) : cand[5:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = sh_q;
  assign remainder_o = rem_q;
  assign busy_o      = busy_q;
  assign done_o      = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/e2c_cal.sv =====
`default_nettype none

// Steps a day count off in four-year blocks, then single years, then months.
module e2c_cal import e2c_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] days_i,
  output logic [7:0]       year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_o,
  output logic             done_o
);

  localparam logic [1:0] CIdle  = 2'd0;
  localparam logic [1:0] CQuad  = 2'd1;
  localparam logic [1:0] CYear  = 2'd2;
  localparam logic [1:0] CMonth = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [15:0] days_q, days_d;
  logic [15:0] ys_q, ys_d;
  logic [7:0]  year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [8:0]  rest_q, rest_d;
  logic        done_q, done_d;
  logic        leap;
  logic [10:0] step;
  logic [16:0] sum;
  logic        fits;
  logic [4:0]  mlen;

  assign leap = (year_q[1:0] == 2'b00);
  assign step = (state_q == CQuad) ? DaysPerQuad : (DaysPerYear + {10'd0, leap});
  assign sum  = {1'b0, ys_q} + {6'd0, step};
  assign fits = (sum <= {1'b0, days_q});
  assign mlen = days_in_month(month_q, leap);

  always_comb begin
    state_d = state_q;
    days_d  = days_q;
    ys_d    = ys_q;
    year_d  = year_q;
    month_d = month_q;
    rest_d  = rest_q;
    done_d  = 1'b0;
    unique case (state_q)
      CIdle: begin
        if (start_i) begin
          days_d  = days_i;
          ys_d    = '0;
          year_d  = '0;
          state_d = CQuad;
        end
      end
      CQuad: begin
        if (fits) begin
          ys_d   = sum[15:0];
          year_d = year_q + 8'd4;
        end else begin
          state_d = CYear;
        end
      end
      CYear: begin
        if (fits) begin
          ys_d   = sum[15:0];
          year_d = year_q + 8'd1;
        end else begin
          rest_d  = 9'(days_q - ys_q);
          month_d = '0;
          state_d = CMonth;
        end
      end
      CMonth: begin
        if ((month_q != MonthDec) && (rest_q >= {4'd0, mlen})) begin
          rest_d  = rest_q - {4'd0, mlen};
          month_d = month_q + 4'd1;
        end else begin
          done_d  = 1'b1;
          state_d = CIdle;
        end
      end
      default: state_d = CIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    days_q  <= days_d;
    ys_q    <= ys_d;
    year_q  <= year_d;
    month_q <= month_d;
    rest_q  <= rest_d;
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = rest_q[4:0] + 5'd1;
  assign done_o  = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/epoch_seconds_to_calendar_date_core.sv =====
// Channel   Dir  Signals                      Content
// s_axis    in   tvalid, tready, tdata[31:0]  seconds since 1972-01-01 00:00:00
// m_axis    out  tvalid, tready, tdata[39:0]  second, minute, hour, weekday,
//                                             year offset, month, day of month
// apb       in   psel, penable, pwrite, paddr[2:0], pwdata/prdata[31:0]
//
// One conversion runs from the accepting edge to the edge that loads the output
// register: four passes of the serial divider (seconds, minutes, hours,
// weekday), then the wait for the calendar stepper. The stepper starts with
// the weekday pass and steps off four-year blocks, then years, then months.
// A new transfer is taken only while the divider is idle, from the cycle after
// the load on. A finished result sits in the output register; a stalled m_axis
// holds it, and the next conversion only waits at its end for that register to
// free. Reset clears control state and sets the epoch weekday register to 6.
`default_nettype none

`include "epoch_seconds_to_calendar_date_core_defines.svh"

module epoch_seconds_to_calendar_date_core import e2c_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] seconds_count
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
  // [19:17] weekday, [27:20] year_offset, [31:28] month_index,
  // [36:32] day_of_month, [39:37] zero
  output logic [39:0]      m_axis_tdata,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Sequencer states: each division pass has its own state, then the block
  // waits for the calendar stepper and a free output register.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSec  = 3'd1;
  localparam logic [2:0] StMin  = 3'd2;
  localparam logic [2:0] StHour = 3'd3;
  localparam logic [2:0] StWday = 3'd4;
  localparam logic [2:0] StWait = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [2:0]      wd_q;
  logic [5:0]      sec_q, sec_d;
  logic [5:0]      min_q, min_d;
  logic [4:0]      hour_q, hour_d;
  logic [2:0]      wday_q, wday_d;
  logic            cal_done_q, cal_done_d;
  logic            out_valid_q, out_valid_d;
  logic [39:0]     out_data_q;
  logic            out_load;

  div_req_t        div_req;
  logic [DivW-1:0] div_dividend;
  logic [DivW-1:0] div_quot;
  logic [5:0]      div_rem;
  logic            div_busy;
  logic            div_done;

  logic            cal_start;
  logic [15:0]     cal_days;
  logic [7:0]      cal_year;
  logic [3:0]      cal_month;
  logic [4:0]      cal_day;
  logic            cal_done;
  logic [16:0]     wday_sum;
  logic            cfg_write;

  // The configuration port has a single register at word 0 and never stalls.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? {29'd0, wd_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_q <= 3'd6;
    end else if (cfg_write) begin
      wd_q <= pwdata[2:0];
    end
  end

  // The weekday is taken as (days + epoch weekday) mod 7 by the same divider.
  assign wday_sum = {1'b0, div_quot[15:0]} + {14'd0, wd_q};

  always_comb begin
    state_d         = state_q;
    sec_d           = sec_q;
    min_d           = min_q;
    hour_d          = hour_q;
    wday_d          = wday_q;
    div_req.start   = 1'b0;
    div_req.divisor = SecPerMin;
    div_dividend    = s_axis_tdata;
    cal_start       = 1'b0;
    cal_days        = div_quot[15:0];
    out_load        = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          div_req.start = 1'b1;
          state_d       = StSec;
        end
      end
      StSec: begin
        if (div_done) begin
          sec_d           = div_rem;
          div_req.start   = 1'b1;
          div_req.divisor = MinPerHour;
          div_dividend    = div_quot;
          state_d         = StMin;
        end
      end
      StMin: begin
        if (div_done) begin
          min_d           = div_rem;
          div_req.start   = 1'b1;
          div_req.divisor = HourPerDay;
          div_dividend    = div_quot;
          state_d         = StHour;
        end
      end
      StHour: begin
        // The quotient is now the whole-day count, below 2^16.
        if (div_done) begin
          hour_d          = div_rem[4:0];
          div_req.start   = 1'b1;
          div_req.divisor = DaysPerWeek;
          div_dividend    = {15'd0, wday_sum};
          cal_start       = 1'b1;
          state_d         = StWday;
        end
      end
      StWday: begin
        if (div_done) begin
          wday_d  = div_rem[2:0];
          state_d = StWait;
        end
      end
      StWait: begin
        if (cal_done_q && (!out_valid_q || m_axis_tready)) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);

  always_comb begin
    cal_done_d = cal_done_q;
    if (cal_start) begin
      cal_done_d = 1'b0;
    end else if (cal_done) begin
      cal_done_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cal_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cal_done_q  <= cal_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q  <= sec_d;
    min_q  <= min_d;
    hour_q <= hour_d;
    wday_q <= wday_d;
    if (out_load) begin
      out_data_q <= {3'd0, cal_day, cal_month, cal_year, wday_q, hour_q, min_q, sec_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  e2c_sdiv u_sdiv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dividend),
    .quotient_o  (div_quot),
    .remainder_o (div_rem),
    .busy_o      (div_busy),
    .done_o      (div_done)
  );

  e2c_cal u_cal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cal_start),
    .days_i  (cal_days),
    .year_o  (cal_year),
    .month_o (cal_month),
    .day_o   (cal_day),
    .done_o  (cal_done)
  );

  // The divider must be free whenever a new transfer can be taken.
  `E2C_ASSERT_IMP(a_idle_div_free, clk_i, rst_ni, s_axis_tready, !div_busy, "divider busy in idle")
  // A finished division only arrives while a division pass is under way.
  `E2C_ASSERT_IMP(a_done_in_pass, clk_i, rst_ni, div_done, (state_q == StSec) || (state_q == StMin) || (state_q == StHour) || (state_q == StWday), "stray divider done")
  // Delivered time fields stay in range.
  `E2C_ASSERT_IMP(a_time_range, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[5:0] < 6'd60) && (m_axis_tdata[11:6] < 6'd60) && (m_axis_tdata[16:12] < 5'd24), "time field out of range")
  // Delivered date fields stay in range.
  `E2C_ASSERT_IMP(a_date_range, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[19:17] < 3'd7) && (m_axis_tdata[31:28] < 4'd12) && (m_axis_tdata[36:32] != 5'd0), "date field out of range")
  // Loading the output register is followed by a valid result.
  `E2C_ASSERT_NXT(a_load_valid, clk_i, rst_ni, out_load, m_axis_tvalid, "loaded result not presented")

endmodule

`default_nettype wire
